// ----- sv/vir_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vir_pkg
// Shared constants and register codes for the voxel inverse rotation lookup.
// ----------------------------------------------------------------------------
package vir_pkg;

	localparam int INDEX_BITS_DEF     = 12;
	localparam int COEF_FRAC_BITS_DEF = 14;

	localparam int LANE_W     = 16;   // spacing and coefficient lanes
	localparam int MIN_W      = 20;   // new minimum lanes
	localparam int SRC_IDX_W  = 36;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;

	localparam logic [47:0] SPACING_RST = 48'h0100_0100_0100;
	localparam logic [59:0] MINIMUM_RST = 60'h0;

	typedef enum logic [2:0] {
		REG_ROT_X       = 3'd0,
		REG_ROT_Y       = 3'd1,
		REG_ROT_Z       = 3'd2,
		REG_NEW_SPACING = 3'd3,
		REG_NEW_MINIMUM = 3'd4,
		REG_OLD_SPACING = 3'd5,
		REG_OLD_DIMS    = 3'd6,
		REG_SLICE_MODE  = 3'd7
	} reg_idx_t;

endpackage
`default_nettype wire

// ----- sv/voxel_inverse_rotation_source_index.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_inverse_rotation_source_index
// Maps an output voxel to its nearest source voxel through the inverse rotation.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | beat
//  vox      | vox_valid/vox_ready, out_col/row/plane     | one output voxel
//  src      | src_valid/src_ready, source_index/valid    | one lookup result
//  apb      | psel/penable/pwrite/paddr/pwdata/prdata    | register access
//
// One beat per cycle while src is not stalled. The pipeline depth is set by the
// rounding divider, one quotient bit per stage, against the old spacing.
// The whole pipeline advances when the output stage is empty or taken, so a
// stall on src freezes every stage. Reset clears stage valid bits and returns the configuration registers to defaults.
module voxel_inverse_rotation_source_index #(
	parameter int INDEX_BITS     = vir_pkg::INDEX_BITS_DEF,
	parameter int COEF_FRAC_BITS = vir_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [vir_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [vir_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [vir_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready,
	input  wire logic                           vox_valid,
	output logic                                vox_ready,
	input  wire logic [INDEX_BITS-1:0]          out_col,
	input  wire logic [INDEX_BITS-1:0]          out_row,
	input  wire logic [INDEX_BITS-1:0]          out_plane,
	output logic                                src_valid,
	input  wire logic                           src_ready,
	output logic [vir_pkg::SRC_IDX_W-1:0]       source_index,
	output logic                                source_valid
);

	localparam int IB  = INDEX_BITS;
	localparam int C   = COEF_FRAC_BITS;
	localparam int LW  = vir_pkg::LANE_W;
	localparam int MW  = vir_pkg::MIN_W;
	localparam int DW  = 3 * IB;
	localparam int PW  = IB + LW + 2;     // position
	localparam int PRW = PW + LW;         // one product
	localparam int NW  = PRW + 2;         // dot product
	localparam int UW  = NW + 2;          // 2n + d
	localparam int UHW = UW - C - 2;      // nonneg u over 2d
	localparam int RW  = LW + IB;         // divider remainder
	localparam int CW  = UHW + 1;
	localparam int SW  = 3 * IB;          // linear index sum

	localparam logic [47:0] ROT_X_RST = 48'(1) << C;
	localparam logic [47:0] ROT_Y_RST = 48'(1) << (C + LW);
	localparam logic [47:0] ROT_Z_RST = 48'(1) << (C + 2 * LW);
	localparam logic [DW-1:0] DIMS_RST = {{(IB-1){1'b0}}, 1'b1,
		{(IB-1){1'b0}}, 1'b1, {(IB-1){1'b0}}, 1'b1};

	// ---------------- configuration registers ----------------
	logic [47:0]    rot_q [3];
	logic [47:0]    new_sp_q;
	logic [59:0]    new_min_q;
	logic [47:0]    old_sp_q;
	logic [DW-1:0]  dims_q;
	logic           slice_q;
	logic [2*IB-1:0] nxy_q;

	vir_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	assign reg_idx = vir_pkg::reg_idx_t'(paddr[5:3]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]  <= ROT_X_RST;
			rot_q[1]  <= ROT_Y_RST;
			rot_q[2]  <= ROT_Z_RST;
			new_sp_q  <= vir_pkg::SPACING_RST;
			new_min_q <= vir_pkg::MINIMUM_RST;
			old_sp_q  <= vir_pkg::SPACING_RST;
			dims_q    <= DIMS_RST;
			slice_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				vir_pkg::REG_ROT_X:       rot_q[0]  <= pwdata[47:0];
				vir_pkg::REG_ROT_Y:       rot_q[1]  <= pwdata[47:0];
				vir_pkg::REG_ROT_Z:       rot_q[2]  <= pwdata[47:0];
				vir_pkg::REG_NEW_SPACING: new_sp_q  <= pwdata[47:0];
				vir_pkg::REG_NEW_MINIMUM: new_min_q <= pwdata[59:0];
				vir_pkg::REG_OLD_SPACING: old_sp_q  <= pwdata[47:0];
				vir_pkg::REG_OLD_DIMS:    dims_q    <= pwdata[DW-1:0];
				vir_pkg::REG_SLICE_MODE:  slice_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// plane stride, refreshed every cycle from the static sizes
	always_ff @(posedge clk) begin
		nxy_q <= dims_q[IB-1:0] * dims_q[2*IB-1:IB];
	end

	always_comb begin
		unique case (reg_idx)
			vir_pkg::REG_ROT_X:       prdata = 64'(rot_q[0]);
			vir_pkg::REG_ROT_Y:       prdata = 64'(rot_q[1]);
			vir_pkg::REG_ROT_Z:       prdata = 64'(rot_q[2]);
			vir_pkg::REG_NEW_SPACING: prdata = 64'(new_sp_q);
			vir_pkg::REG_NEW_MINIMUM: prdata = 64'(new_min_q);
			vir_pkg::REG_OLD_SPACING: prdata = 64'(old_sp_q);
			vir_pkg::REG_OLD_DIMS:    prdata = 64'(dims_q);
			vir_pkg::REG_SLICE_MODE:  prdata = 64'(slice_q);
			default:                  prdata = '0;
		endcase
	end

	// ---------------- pipeline ----------------
	logic adv;
	assign adv       = !src_valid || src_ready;
	assign vox_ready = adv;

	// s1: physical position
	logic                 vld_s1;
	logic [IB-1:0]        plane_s1;
	logic signed [PW-1:0] pos_s1 [3];
	logic [IB-1:0]        idx_in [3];
	logic signed [PW-1:0] pos_d [3];

	assign idx_in[0] = out_col;
	assign idx_in[1] = out_row;
	assign idx_in[2] = out_plane;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [IB+LW-1:0] sc;
			logic [MW-1:0]    mn;
			sc = idx_in[a] * new_sp_q[LW*a +: LW];
			mn = new_min_q[MW*a +: MW];
			pos_d[a] = $signed({2'b00, sc}) + $signed({{(PW-MW){mn[MW-1]}}, mn});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= vox_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plane_s1 <= out_plane;
			for (int a = 0; a < 3; a++) pos_s1[a] <= pos_d[a];
		end
	end

	// s2: nine products
	logic                  vld_s2;
	logic [IB-1:0]         plane_s2;
	logic signed [PRW-1:0] prod_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plane_s2 <= plane_s1;
			for (int r = 0; r < 3; r++)
				for (int a = 0; a < 3; a++)
					prod_s2[r][a] <= pos_s1[a] * $signed(rot_q[r][LW*a +: LW]);
		end
	end

	// s3: dot product, biased by half a divisor for rounding
	logic           vld_s3;
	logic [IB-1:0]  plane_s3;
	logic           neg_s3 [3];
	logic           lowz_s3 [3];
	logic [UHW-1:0] uh_s3 [3];
	logic signed [UW-1:0] u_d [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			logic signed [NW-1:0] n;
			n = NW'(prod_s2[r][0]) + NW'(prod_s2[r][1]) + NW'(prod_s2[r][2]);
			u_d[r] = $signed({n[NW-1], n, 1'b0})
				+ $signed({{(UW-LW-C){1'b0}}, old_sp_q[LW*r +: LW], {C{1'b0}}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plane_s3 <= plane_s2;
			for (int r = 0; r < 3; r++) begin
				neg_s3[r]  <= u_d[r][UW-1];
				lowz_s3[r] <= (u_d[r][C:0] == '0);
				uh_s3[r]   <= u_d[r][UW-2:C+1];
			end
		end
	end

	// s4 and divider: floor(uh / sp), one quotient bit per stage
	typedef struct packed {
		logic          bad;
		logic          lowz;
		logic [RW-1:0] rem;
		logic [IB-1:0] q;
	} dax_t;

	typedef struct packed {
		logic          vld;
		logic [IB-1:0] plane;
		dax_t [2:0]    ax;
	} dstg_t;

	dstg_t div_s [0:IB];
	dstg_t div_d;

	always_comb begin
		div_d.vld   = vld_s3;
		div_d.plane = plane_s3;
		for (int a = 0; a < 3; a++) begin
			logic [LW-1:0] sp;
			logic          ovf;
			sp  = old_sp_q[LW*a +: LW];
			ovf = {1'b0, uh_s3[a]} >= {{(CW-RW){1'b0}}, sp, {IB{1'b0}}};
			div_d.ax[a].bad  = neg_s3[a] | ovf | (sp == '0);
			div_d.ax[a].lowz = lowz_s3[a];
			div_d.ax[a].rem  = uh_s3[a][RW-1:0];
			div_d.ax[a].q    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_s[0] <= '0;
		else if (adv) div_s[0] <= div_d;
	end

	for (genvar k = 0; k < IB; k++) begin : g_div
		localparam int B = IB - 1 - k;
		dstg_t nxt;

		always_comb begin
			nxt = div_s[k];
			for (int a = 0; a < 3; a++) begin
				logic [RW:0] trial;
				trial = {1'b0, div_s[k].ax[a].rem}
					- {1'b0, RW'(old_sp_q[LW*a +: LW]) << B};
				if (!trial[RW]) begin
					nxt.ax[a].rem  = trial[RW-1:0];
					nxt.ax[a].q[B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_s[k+1] <= '0;
			else if (adv) div_s[k+1] <= nxt;
		end
	end

	// round: ties to even, then bounds; in slice mode the plane axis takes out_plane as is
	logic          vld_r;
	logic [IB-1:0] qv_d [3];
	logic          ok_d [3];
	logic          vld_rnd_s;
	logic          ok_rnd_s;
	logic [IB-1:0] q_rnd_s [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dax_t   x;
			logic   tie;
			x   = div_s[IB].ax[a];
			tie = x.lowz && (x.rem == '0);
			qv_d[a] = (tie && x.q[0]) ? x.q - 1'b1 : x.q;
			ok_d[a] = !x.bad && (qv_d[a] < dims_q[IB*a +: IB]);
		end
		if (slice_q) begin
			qv_d[2] = div_s[IB].plane;
			ok_d[2] = div_s[IB].plane < dims_q[2*IB +: IB];
		end
	end

	assign vld_r = div_s[IB].vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_rnd_s <= 1'b0;
		else if (adv) vld_rnd_s <= vld_r;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_rnd_s <= ok_d[0] & ok_d[1] & ok_d[2];
			for (int a = 0; a < 3; a++) q_rnd_s[a] <= qv_d[a];
		end
	end

	// strides
	logic            vld_mul_s;
	logic            ok_mul_s;
	logic [IB-1:0]   q0_mul_s;
	logic [2*IB-1:0] m1_mul_s;
	logic [SW-1:0]   m2_mul_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_mul_s <= 1'b0;
		else if (adv) vld_mul_s <= vld_rnd_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_mul_s <= ok_rnd_s;
			q0_mul_s <= q_rnd_s[0];
			m1_mul_s <= dims_q[IB-1:0] * q_rnd_s[1];
			m2_mul_s <= nxy_q * q_rnd_s[2];
		end
	end

	// output register
	logic [SW-1:0] lin_d;
	assign lin_d = m2_mul_s + SW'(m1_mul_s) + SW'(q0_mul_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) src_valid <= 1'b0;
		else if (adv) src_valid <= vld_mul_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			source_valid <= ok_mul_s;
			source_index <= ok_mul_s ? vir_pkg::SRC_IDX_W'(lin_d) : '0;
		end
	end

endmodule
`default_nettype wire
